FILE: hw/rtl/iaa_pkg.sv
package iaa_pkg;

   localparam int DEF_VALUE_WIDTH    = 32;
   localparam int DEF_FRACTION_BITS  = 16;
   // quotient bits resolved per divider stage
   localparam int DIV_BITS_PER_STAGE = 2;

   typedef enum logic [3:0] {
      CMD_ADD = 4'd0,
      CMD_SUB = 4'd1,
      CMD_MUL = 4'd2,
      CMD_DIV = 4'd3,
      CMD_LT  = 4'd4,
      CMD_GT  = 4'd5,
      CMD_LE  = 4'd6,
      CMD_GE  = 4'd7,
      CMD_EQ  = 4'd8,
      CMD_NOT = 4'd9,
      CMD_OR  = 4'd10,
      CMD_AND = 4'd11,
      CMD_NEG = 4'd12
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_UNKNOWN  = 3'd0,
      KIND_FALSE    = 3'd1,
      KIND_TRUE     = 3'd2,
      KIND_MIXED    = 3'd3,
      KIND_INTERVAL = 3'd4,
      KIND_NUMBER   = 3'd5
   } kind_type;

   // where the final bounds come from
   typedef enum logic [1:0] {
      MODE_SIMPLE = 2'd0,
      MODE_MUL    = 2'd1,
      MODE_DIV    = 2'd2
   } mode_type;

   function automatic logic is_real(kind_type k);
      return (k == KIND_INTERVAL) || (k == KIND_NUMBER);
   endfunction

   function automatic logic is_bool(kind_type k);
      return (k == KIND_FALSE) || (k == KIND_TRUE) || (k == KIND_MIXED);
   endfunction

   function automatic kind_type tri_or(kind_type x, kind_type y);
      kind_type r;
      if (!is_bool(x) || !is_bool(y)) r = KIND_UNKNOWN;
      else if (x == KIND_FALSE) r = y;
      else if (y == KIND_FALSE) r = x;
      else if (x == KIND_TRUE || y == KIND_TRUE) r = KIND_TRUE;
      else r = KIND_MIXED;
      return r;
   endfunction

   function automatic kind_type tri_and(kind_type x, kind_type y);
      kind_type r;
      if (!is_bool(x) || !is_bool(y)) r = KIND_UNKNOWN;
      else if (x == KIND_TRUE) r = y;
      else if (y == KIND_TRUE) r = x;
      else if (x == KIND_FALSE || y == KIND_FALSE) r = KIND_FALSE;
      else r = KIND_MIXED;
      return r;
   endfunction

endpackage

FILE: hw/rtl/iaa_sat.sv
// magnitude + sign -> saturated signed value
module iaa_sat #(
   parameter int VALUE_WIDTH = 32,
   parameter int MAG_WIDTH   = 32
) (
   input  logic [MAG_WIDTH-1:0]          mag,
   input  logic                          neg,
   input  logic                          ovf,
   output logic signed [VALUE_WIDTH-1:0] value
);

   localparam int W  = VALUE_WIDTH;
   localparam int MW = MAG_WIDTH;
   localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

   logic over;

   always_comb begin
      over = neg ? (mag > HALF) : (mag >= HALF);
      if (ovf || over) begin
         value = neg ? VMIN : VMAX;
      end else if (neg) begin
         value = -$signed(mag[W-1:0]);
      end else begin
         value = $signed(mag[W-1:0]);
      end
   end

endmodule

FILE: hw/rtl/iaa_mul4.sv
// four endpoint magnitude products: lane = {a select, b select}
module iaa_mul4 #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic [1:0][VALUE_WIDTH-1:0]   a_mag,
   input  logic [1:0][VALUE_WIDTH-1:0]   b_mag,
   output logic [3:0][2*VALUE_WIDTH-1:0] prod
);

   localparam int W = VALUE_WIDTH;

   for (genvar l = 0; l < 4; l++) begin : g_lane
      assign prod[l] = (2*W)'(a_mag[l / 2]) * (2*W)'(b_mag[l % 2]);
   end

endmodule

FILE: hw/rtl/iaa_div.sv
// four-lane pipelined restoring divider, fixed-point quotient magnitude
module iaa_div import iaa_pkg::*; #(
   parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS,
   parameter int SIDE_WIDTH    = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [3:0][VALUE_WIDTH-1:0]  in_n,
   input  logic [3:0][VALUE_WIDTH-1:0]  in_d,
   input  logic [3:0]                   in_neg,
   input  logic [SIDE_WIDTH-1:0]        in_side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [3:0][VALUE_WIDTH-1:0]  out_q,
   output logic [3:0]                   out_ovf,
   output logic [3:0]                   out_neg,
   output logic [SIDE_WIDTH-1:0]        out_side
);

   localparam int W      = VALUE_WIDTH;
   localparam int F      = FRACTION_BITS;
   localparam int BPS    = DIV_BITS_PER_STAGE;
   localparam int STAGES = (W + BPS - 1) / BPS;
   localparam int T      = STAGES * BPS;
   localparam int NW     = W + F;
   localparam int CW     = W + ((F > W) ? F : W) + 1;

   logic [STAGES:0] v_ff, v_in, en;

   logic [3:0][W-1:0]      rem_ff  [STAGES+1];
   logic [3:0][W-1:0]      rem_in  [STAGES+1];
   logic [3:0][T-1:0]      low_ff  [STAGES+1];
   logic [3:0][T-1:0]      low_in  [STAGES+1];
   logic [3:0][W-1:0]      q_ff    [STAGES+1];
   logic [3:0][W-1:0]      q_in    [STAGES+1];
   logic [3:0][W-1:0]      d_ff    [STAGES+1];
   logic [3:0][W-1:0]      d_in    [STAGES+1];
   logic [3:0]             neg_ff  [STAGES+1];
   logic [3:0]             neg_in  [STAGES+1];
   logic [3:0]             ovf_ff  [STAGES+1];
   logic [3:0]             ovf_in  [STAGES+1];
   logic [SIDE_WIDTH-1:0]  side_ff [STAGES+1];
   logic [SIDE_WIDTH-1:0]  side_in [STAGES+1];

   // stall chain: a stage moves when empty or when its successor moves
   always_comb begin
      en[STAGES] = !v_ff[STAGES] || out_ready;
      for (int s = STAGES - 1; s >= 0; s--) begin
         en[s] = !v_ff[s] || en[s+1];
      end
      v_in[0] = in_valid;
      for (int s = 1; s <= STAGES; s++) begin
         v_in[s] = v_ff[s-1];
      end
   end

   assign in_ready = en[0];

   // entry splits the numerator and flags quotients that need more than W bits;
   // every later stage does BPS restoring steps
   always_comb begin
      logic [NW-1:0] num;
      logic [W-1:0]  r;
      logic [T-1:0]  lw;
      logic [W-1:0]  qq;
      logic [W:0]    t;
      logic          qbit;
      for (int l = 0; l < 4; l++) begin
         num          = NW'({in_n[l], {F{1'b0}}});
         rem_in[0][l] = W'(num >> T);
         low_in[0][l] = num[T-1:0];
         q_in[0][l]   = '0;
         d_in[0][l]   = in_d[l];
         ovf_in[0][l] = (CW'(in_n[l]) << F) >= (CW'(in_d[l]) << W);
      end
      neg_in[0]  = in_neg;
      side_in[0] = in_side;
      for (int s = 1; s <= STAGES; s++) begin
         for (int l = 0; l < 4; l++) begin
            r  = rem_ff[s-1][l];
            lw = low_ff[s-1][l];
            qq = q_ff[s-1][l];
            for (int k = 0; k < BPS; k++) begin
               t    = {r, lw[T-1]};
               lw   = lw << 1;
               qbit = (t >= {1'b0, d_ff[s-1][l]});
               if (qbit) begin
                  t = t - {1'b0, d_ff[s-1][l]};
               end
               r  = t[W-1:0];
               qq = {qq[W-2:0], qbit};
            end
            rem_in[s][l] = r;
            low_in[s][l] = lw;
            q_in[s][l]   = qq;
            d_in[s][l]   = d_ff[s-1][l];
         end
         neg_in[s]  = neg_ff[s-1];
         ovf_in[s]  = ovf_ff[s-1];
         side_in[s] = side_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s <= STAGES; s++) begin
            if (en[s]) v_ff[s] <= v_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= STAGES; s++) begin
         if (en[s]) begin
            rem_ff[s]  <= rem_in[s];
            low_ff[s]  <= low_in[s];
            q_ff[s]    <= q_in[s];
            d_ff[s]    <= d_in[s];
            neg_ff[s]  <= neg_in[s];
            ovf_ff[s]  <= ovf_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_valid = v_ff[STAGES];
   assign out_q     = q_ff[STAGES];
   assign out_ovf   = ovf_ff[STAGES];
   assign out_neg   = neg_ff[STAGES];
   assign out_side  = side_ff[STAGES];

endmodule

FILE: hw/rtl/interval_arithmetic_alu.sv
// Throughput: one item per cycle while rsp_ready is high; the divider resolves 2 quotient bits per stage
// and every stage advances when empty or when the next one advances.
// Reset (synchronous, active high) empties every stage; payload registers are not reset.
module interval_arithmetic_alu import iaa_pkg::*; #(
   parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [3:0]                    req_command,
   input  logic [2:0]                    req_a_kind,
   input  logic signed [VALUE_WIDTH-1:0] req_a_lower,
   input  logic signed [VALUE_WIDTH-1:0] req_a_upper,
   input  logic [2:0]                    req_b_kind,
   input  logic signed [VALUE_WIDTH-1:0] req_b_lower,
   input  logic signed [VALUE_WIDTH-1:0] req_b_upper,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_result_kind,
   output logic signed [VALUE_WIDTH-1:0] rsp_result_lower,
   output logic signed [VALUE_WIDTH-1:0] rsp_result_upper
);

   localparam int W  = VALUE_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int SW = 2 + 3 + 2*W + 8*W;   // mode, kind, bounds, products
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

   // -----------------------------------------------------------------------
   // helpers
   // -----------------------------------------------------------------------
   function automatic logic signed [W-1:0] f_sat(logic [W:0] s);
      logic signed [W-1:0] r;
      if (s[W] != s[W-1]) r = s[W] ? VMIN : VMAX;
      else r = $signed(s[W-1:0]);
      return r;
   endfunction

   function automatic logic signed [W-1:0] f_neg(logic signed [W-1:0] x);
      return (x == VMIN) ? VMAX : -x;
   endfunction

   function automatic kind_type f_lt(kind_type xk, kind_type yk,
                                     logic signed [W-1:0] xlo, logic signed [W-1:0] xhi,
                                     logic signed [W-1:0] ylo, logic signed [W-1:0] yhi);
      kind_type r;
      if (xk == KIND_NUMBER && yk == KIND_NUMBER) r = (xlo < ylo) ? KIND_TRUE : KIND_FALSE;
      else if (!is_real(xk) || !is_real(yk)) r = KIND_UNKNOWN;
      else if (xhi < ylo) r = KIND_TRUE;
      else if (yhi < xlo) r = KIND_FALSE;
      else r = KIND_MIXED;
      return r;
   endfunction

   function automatic logic signed [W-1:0] f_min(logic signed [W-1:0] x,
                                                 logic signed [W-1:0] y);
      return (y < x) ? y : x;
   endfunction

   function automatic logic signed [W-1:0] f_max(logic signed [W-1:0] x,
                                                 logic signed [W-1:0] y);
      return (y > x) ? y : x;
   endfunction

   // -----------------------------------------------------------------------
   // handshake chain (rsp side back to req side)
   // -----------------------------------------------------------------------
   logic en1, en2, enf, eno;
   logic v1_ff, v2_ff, vf_ff, rsp_valid_ff;
   logic div_in_ready, div_out_valid;

   assign eno       = !rsp_valid_ff || rsp_ready;
   assign enf       = !vf_ff || eno;
   assign en2       = !v2_ff || div_in_ready;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   // -----------------------------------------------------------------------
   // stage 1: capture item, normalize operand kinds
   // -----------------------------------------------------------------------
   cmd_type             cmd1_ff;
   kind_type            ak1_ff, bk1_ff, ak1_in, bk1_in;
   logic signed [W-1:0] alo1_ff, ahi1_ff, blo1_ff, bhi1_ff;
   logic signed [W-1:0] alo1_in, ahi1_in, blo1_in, bhi1_in;

   always_comb begin
      ak1_in  = (req_a_kind <= 3'(KIND_NUMBER)) ? kind_type'(req_a_kind) : KIND_UNKNOWN;
      bk1_in  = (req_b_kind <= 3'(KIND_NUMBER)) ? kind_type'(req_b_kind) : KIND_UNKNOWN;
      alo1_in = '0;
      ahi1_in = '0;
      blo1_in = '0;
      bhi1_in = '0;
      // a number carries its value in both bounds; booleans carry zeros
      case (ak1_in)
         KIND_INTERVAL: begin
            alo1_in = req_a_lower;
            ahi1_in = req_a_upper;
         end
         KIND_NUMBER: begin
            alo1_in = req_a_lower;
            ahi1_in = req_a_lower;
         end
         default: ;
      endcase
      case (bk1_in)
         KIND_INTERVAL: begin
            blo1_in = req_b_lower;
            bhi1_in = req_b_upper;
         end
         KIND_NUMBER: begin
            blo1_in = req_b_lower;
            bhi1_in = req_b_lower;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en1) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         cmd1_ff <= cmd_type'(req_command);
         ak1_ff  <= ak1_in;
         bk1_ff  <= bk1_in;
         alo1_ff <= alo1_in;
         ahi1_ff <= ahi1_in;
         blo1_ff <= blo1_in;
         bhi1_ff <= bhi1_in;
      end
   end

   // -----------------------------------------------------------------------
   // stage 2: everything that is not a product or quotient, plus magnitudes
   // -----------------------------------------------------------------------
   mode_type            mode2_ff, mode2_in;
   kind_type            kind2_ff, kind2_in;
   logic signed [W-1:0] lo2_ff, hi2_ff, lo2_in, hi2_in;
   logic [1:0][W-1:0]   a_mag2_ff, b_mag2_ff, a_mag2_in, b_mag2_in;
   logic [1:0]          a_sgn2_ff, b_sgn2_ff;

   always_comb begin
      logic                both_num, both_real;
      kind_type            lt_ab, lt_ba, eq_ab, sk, rk;
      logic signed [W-1:0] rlo, rhi;

      both_num  = (ak1_ff == KIND_NUMBER) && (bk1_ff == KIND_NUMBER);
      both_real = is_real(ak1_ff) && is_real(bk1_ff);
      lt_ab     = f_lt(ak1_ff, bk1_ff, alo1_ff, ahi1_ff, blo1_ff, bhi1_ff);
      lt_ba     = f_lt(bk1_ff, ak1_ff, blo1_ff, bhi1_ff, alo1_ff, ahi1_ff);
      if (both_num) eq_ab = (alo1_ff == blo1_ff) ? KIND_TRUE : KIND_FALSE;
      else if (!both_real) eq_ab = KIND_UNKNOWN;
      else if (lt_ab == KIND_TRUE || lt_ab == KIND_FALSE) eq_ab = KIND_FALSE;
      else eq_ab = KIND_MIXED;

      // boolean times real: pick which side is the boolean
      if (is_bool(ak1_ff)) begin
         sk  = ak1_ff;
         rk  = bk1_ff;
         rlo = blo1_ff;
         rhi = bhi1_ff;
      end else begin
         sk  = bk1_ff;
         rk  = ak1_ff;
         rlo = alo1_ff;
         rhi = ahi1_ff;
      end

      mode2_in = MODE_SIMPLE;
      kind2_in = KIND_UNKNOWN;
      lo2_in   = '0;
      hi2_in   = '0;

      case (cmd1_ff)
         CMD_ADD: begin
            if (both_real) begin
               kind2_in = both_num ? KIND_NUMBER : KIND_INTERVAL;
               lo2_in   = f_sat({alo1_ff[W-1], alo1_ff} + {blo1_ff[W-1], blo1_ff});
               hi2_in   = f_sat({ahi1_ff[W-1], ahi1_ff} + {bhi1_ff[W-1], bhi1_ff});
            end
         end
         CMD_SUB: begin
            if (both_real) begin
               kind2_in = both_num ? KIND_NUMBER : KIND_INTERVAL;
               lo2_in   = f_sat({alo1_ff[W-1], alo1_ff} - {bhi1_ff[W-1], bhi1_ff});
               hi2_in   = f_sat({ahi1_ff[W-1], ahi1_ff} - {blo1_ff[W-1], blo1_ff});
            end
         end
         CMD_MUL: begin
            if (both_real) begin
               mode2_in = MODE_MUL;
               kind2_in = both_num ? KIND_NUMBER : KIND_INTERVAL;
            end else if (is_bool(sk) && is_real(rk)) begin
               case (sk)
                  KIND_TRUE: begin
                     kind2_in = rk;
                     lo2_in   = rlo;
                     hi2_in   = rhi;
                  end
                  KIND_FALSE: begin
                     kind2_in = KIND_NUMBER;
                  end
                  default: begin
                     // mixed: widen to include zero
                     kind2_in = KIND_INTERVAL;
                     lo2_in   = (rlo < 0) ? rlo : '0;
                     hi2_in   = (rhi > 0) ? rhi : '0;
                  end
               endcase
            end else begin
               kind2_in = tri_and(ak1_ff, bk1_ff);
            end
         end
         CMD_DIV: begin
            if (both_real) begin
               // divisor must exclude zero strictly at both ends
               if ((blo1_ff > 0 || bhi1_ff < 0) && blo1_ff != 0 && bhi1_ff != 0) begin
                  mode2_in = MODE_DIV;
                  kind2_in = both_num ? KIND_NUMBER : KIND_INTERVAL;
               end else begin
                  kind2_in = KIND_INTERVAL;
                  lo2_in   = VMIN;
                  hi2_in   = VMAX;
               end
            end
         end
         CMD_LT:  kind2_in = lt_ab;
         CMD_GT:  kind2_in = lt_ba;
         CMD_LE:  kind2_in = tri_or(lt_ab, eq_ab);
         CMD_GE:  kind2_in = tri_or(lt_ba, eq_ab);
         CMD_EQ:  kind2_in = eq_ab;
         CMD_NOT: begin
            case (ak1_ff)
               KIND_TRUE:  kind2_in = KIND_FALSE;
               KIND_FALSE: kind2_in = KIND_TRUE;
               KIND_MIXED: kind2_in = KIND_MIXED;
               default:    kind2_in = KIND_UNKNOWN;
            endcase
         end
         CMD_OR:  kind2_in = tri_or(ak1_ff, bk1_ff);
         CMD_AND: kind2_in = tri_and(ak1_ff, bk1_ff);
         CMD_NEG: begin
            if (ak1_ff == KIND_NUMBER || ak1_ff == KIND_INTERVAL) begin
               kind2_in = ak1_ff;
               lo2_in   = f_neg(ahi1_ff);
               hi2_in   = f_neg(alo1_ff);
            end
         end
         default: ;
      endcase

      a_mag2_in[0] = alo1_ff[W-1] ? W'(-alo1_ff) : W'(alo1_ff);
      a_mag2_in[1] = ahi1_ff[W-1] ? W'(-ahi1_ff) : W'(ahi1_ff);
      b_mag2_in[0] = blo1_ff[W-1] ? W'(-blo1_ff) : W'(blo1_ff);
      b_mag2_in[1] = bhi1_ff[W-1] ? W'(-bhi1_ff) : W'(bhi1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en2) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         mode2_ff  <= mode2_in;
         kind2_ff  <= kind2_in;
         lo2_ff    <= lo2_in;
         hi2_ff    <= hi2_in;
         a_mag2_ff <= a_mag2_in;
         b_mag2_ff <= b_mag2_in;
         a_sgn2_ff <= {ahi1_ff[W-1], alo1_ff[W-1]};
         b_sgn2_ff <= {bhi1_ff[W-1], blo1_ff[W-1]};
      end
   end

   // -----------------------------------------------------------------------
   // products enter the divider pipeline as sideband and ride along
   // lane order: lo*lo, lo*hi, hi*lo, hi*hi (a first)
   // -----------------------------------------------------------------------
   logic [3:0][2*W-1:0] prod;
   logic [3:0][W-1:0]   div_n, div_d, div_q;
   logic [3:0]          div_neg_in, div_neg, div_ovf;
   logic [SW-1:0]       div_side_in, div_side;

   iaa_mul4 #(
      .VALUE_WIDTH (W)
   ) u_mul (
      .a_mag (a_mag2_ff),
      .b_mag (b_mag2_ff),
      .prod  (prod)
   );

   for (genvar l = 0; l < 4; l++) begin : g_lane_in
      assign div_n[l]      = a_mag2_ff[l / 2];
      assign div_d[l]      = b_mag2_ff[l % 2];
      assign div_neg_in[l] = a_sgn2_ff[l / 2] ^ b_sgn2_ff[l % 2];
   end

   assign div_side_in = {mode2_ff, kind2_ff, lo2_ff, hi2_ff, prod};

   iaa_div #(
      .VALUE_WIDTH   (W),
      .FRACTION_BITS (F),
      .SIDE_WIDTH    (SW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_ready  (div_in_ready),
      .in_n      (div_n),
      .in_d      (div_d),
      .in_neg    (div_neg_in),
      .in_side   (div_side_in),
      .out_valid (div_out_valid),
      .out_ready (enf),
      .out_q     (div_q),
      .out_ovf   (div_ovf),
      .out_neg   (div_neg),
      .out_side  (div_side)
   );

   // -----------------------------------------------------------------------
   // finish stage: saturate the four quotients and four products
   // -----------------------------------------------------------------------
   logic [1:0]          d_mode_bits;
   logic [2:0]          d_kind_bits;
   logic signed [W-1:0] d_lo, d_hi;
   logic [3:0][2*W-1:0] d_prod;
   logic signed [W-1:0] qs_in [4];
   logic signed [W-1:0] ps_in [4];

   assign {d_mode_bits, d_kind_bits, d_lo, d_hi, d_prod} = div_side;

   for (genvar l = 0; l < 4; l++) begin : g_sat
      iaa_sat #(
         .VALUE_WIDTH (W),
         .MAG_WIDTH   (W)
      ) u_qsat (
         .mag   (div_q[l]),
         .neg   (div_neg[l]),
         .ovf   (div_ovf[l]),
         .value (qs_in[l])
      );

      // products are truncated toward zero by dropping fraction bits
      iaa_sat #(
         .VALUE_WIDTH (W),
         .MAG_WIDTH   (2*W)
      ) u_psat (
         .mag   (d_prod[l] >> F),
         .neg   (div_neg[l]),
         .ovf   (1'b0),
         .value (ps_in[l])
      );
   end

   mode_type            modef_ff;
   kind_type            kindf_ff;
   logic signed [W-1:0] lof_ff, hif_ff;
   logic signed [W-1:0] qs_ff [4];
   logic signed [W-1:0] ps_ff [4];

   always_ff @(posedge clock) begin
      if (reset) vf_ff <= 1'b0;
      else if (enf) vf_ff <= div_out_valid;
   end

   always_ff @(posedge clock) begin
      if (enf) begin
         modef_ff <= mode_type'(d_mode_bits);
         kindf_ff <= kind_type'(d_kind_bits);
         lof_ff   <= d_lo;
         hif_ff   <= d_hi;
         qs_ff    <= qs_in;
         ps_ff    <= ps_in;
      end
   end

   // -----------------------------------------------------------------------
   // output stage: min/max over the four endpoint results, final select
   // -----------------------------------------------------------------------
   kind_type            kindo_in;
   logic signed [W-1:0] loo_in, hio_in;
   kind_type            rsp_kind_ff;
   logic signed [W-1:0] rsp_lo_ff, rsp_hi_ff;

   always_comb begin
      logic signed [W-1:0] c [4];
      case (modef_ff)
         MODE_MUL: c = ps_ff;
         default:  c = qs_ff;
      endcase
      kindo_in = kindf_ff;
      case (modef_ff)
         MODE_MUL, MODE_DIV: begin
            loo_in = f_min(f_min(c[0], c[1]), f_min(c[2], c[3]));
            hio_in = f_max(f_max(c[0], c[1]), f_max(c[2], c[3]));
         end
         default: begin
            loo_in = lof_ff;
            hio_in = hif_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (eno) rsp_valid_ff <= vf_ff;
   end

   always_ff @(posedge clock) begin
      if (eno) begin
         rsp_kind_ff <= kindo_in;
         rsp_lo_ff   <= loo_in;
         rsp_hi_ff   <= hio_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_lower = rsp_lo_ff;
   assign rsp_result_upper = rsp_hi_ff;

endmodule

FILE: dv/interval_arithmetic_alu_tb.sv
`timescale 1ns / 100ps

module interval_arithmetic_alu_tb import iaa_pkg::*; ();

   localparam int  WIDTH      = DEF_VALUE_WIDTH;
   localparam int  FRAC       = DEF_FRACTION_BITS;
   localparam longint VAL_MAX = (64'sd1 <<< (WIDTH - 1)) - 1;
   localparam longint VAL_MIN = -VAL_MAX - 1;
   localparam int  HOLD_CYCLES = 300;
   localparam int  DRAIN_CYCLES = 40;

   // one request item as it appears on the req_ ports
   typedef struct {
      logic [3:0]       command;
      logic [2:0]       a_kind;
      logic [WIDTH-1:0] a_lower;
      logic [WIDTH-1:0] a_upper;
      logic [2:0]       b_kind;
      logic [WIDTH-1:0] b_lower;
      logic [WIDTH-1:0] b_upper;
   } req_item_type;

   // operand or result inside the predictor, bounds at full precision
   typedef struct {
      kind_type kind;
      longint   lo;
      longint   hi;
   } ival_type;

   // result item as it appears on the rsp_ ports
   typedef struct {
      logic [2:0]       kind;
      logic [WIDTH-1:0] lower;
      logic [WIDTH-1:0] upper;
   } rsp_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [3:0]       req_command = '0;
   logic [2:0]       req_a_kind = '0;
   logic [WIDTH-1:0] req_a_lower = '0;
   logic [WIDTH-1:0] req_a_upper = '0;
   logic [2:0]       req_b_kind = '0;
   logic [WIDTH-1:0] req_b_lower = '0;
   logic [WIDTH-1:0] req_b_upper = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [2:0]       rsp_result_kind;
   logic [WIDTH-1:0] rsp_result_lower;
   logic [WIDTH-1:0] rsp_result_upper;

   req_item_type pending_items[$];
   rsp_item_type expected_results[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  hold_requests = 0;
   int  hold_served   = 0;
   int  hold_left     = 0;
   int  mismatches    = 0;
   int  items_sent    = 0;
   int  results_seen  = 0;
   bit  req_taken     = 1'b0;

   interval_arithmetic_alu u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_a_kind       (req_a_kind),
      .req_a_lower      (req_a_lower),
      .req_a_upper      (req_a_upper),
      .req_b_kind       (req_b_kind),
      .req_b_lower      (req_b_lower),
      .req_b_upper      (req_b_upper),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_result_lower (rsp_result_lower),
      .rsp_result_upper (rsp_result_upper)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor: interval arithmetic on Q16.16 with saturation
   // ------------------------------------------------------------------
   function automatic longint clip(longint v);
      if (v > VAL_MAX) return VAL_MAX;
      if (v < VAL_MIN) return VAL_MIN;
      return v;
   endfunction

   function automatic longint sext(logic [WIDTH-1:0] x);
      return longint'($signed(x));
   endfunction

   function automatic bit is_real_kind(ival_type v);
      return v.kind == KIND_INTERVAL || v.kind == KIND_NUMBER;
   endfunction

   function automatic bit is_bool_kind(ival_type v);
      return v.kind == KIND_FALSE || v.kind == KIND_TRUE || v.kind == KIND_MIXED;
   endfunction

   function automatic ival_type make(kind_type k, longint lo, longint hi);
      ival_type r;
      r.kind = k;
      r.lo   = lo;
      r.hi   = hi;
      return r;
   endfunction

   function automatic ival_type truth(bit t);
      return make(t ? KIND_TRUE : KIND_FALSE, 0, 0);
   endfunction

   // product truncated toward zero; operands fit 32 bits so 64 suffice
   function automatic longint q_mul(longint a, longint b);
      longint p, m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = m >>> FRAC;
      return clip((p < 0) ? -m : m);
   endfunction

   // divisor must be nonzero
   function automatic longint q_div(longint a, longint b);
      longint n, d, q;
      n = ((a < 0) ? -a : a) <<< FRAC;
      d = (b < 0) ? -b : b;
      q = n / d;
      return clip(((a < 0) != (b < 0)) ? -q : q);
   endfunction

   function automatic ival_type span4(longint c0, longint c1, longint c2, longint c3);
      longint lo, hi;
      lo = c0;
      hi = c0;
      if (c1 < lo) lo = c1;
      if (c1 > hi) hi = c1;
      if (c2 < lo) lo = c2;
      if (c2 > hi) hi = c2;
      if (c3 < lo) lo = c3;
      if (c3 > hi) hi = c3;
      return make(KIND_INTERVAL, lo, hi);
   endfunction

   function automatic ival_type logic_or(ival_type a, ival_type b);
      if (!is_bool_kind(a) || !is_bool_kind(b)) return make(KIND_UNKNOWN, 0, 0);
      if (a.kind == KIND_FALSE) return b;
      if (b.kind == KIND_FALSE) return a;
      if (a.kind == KIND_TRUE || b.kind == KIND_TRUE) return truth(1'b1);
      return make(KIND_MIXED, 0, 0);
   endfunction

   function automatic ival_type logic_and(ival_type a, ival_type b);
      if (!is_bool_kind(a) || !is_bool_kind(b)) return make(KIND_UNKNOWN, 0, 0);
      if (a.kind == KIND_TRUE) return b;
      if (b.kind == KIND_TRUE) return a;
      if (a.kind == KIND_FALSE || b.kind == KIND_FALSE) return truth(1'b0);
      return make(KIND_MIXED, 0, 0);
   endfunction

   function automatic ival_type is_below(ival_type a, ival_type b);
      if (a.kind == KIND_NUMBER && b.kind == KIND_NUMBER) return truth(a.lo < b.lo);
      if (!is_real_kind(a) || !is_real_kind(b)) return make(KIND_UNKNOWN, 0, 0);
      if (a.hi < b.lo) return truth(1'b1);
      if (b.hi < a.lo) return truth(1'b0);
      return make(KIND_MIXED, 0, 0);
   endfunction

   function automatic ival_type equal_to(ival_type a, ival_type b);
      ival_type t;
      if (a.kind == KIND_NUMBER && b.kind == KIND_NUMBER) return truth(a.lo == b.lo);
      if (!is_real_kind(a) || !is_real_kind(b)) return make(KIND_UNKNOWN, 0, 0);
      t = is_below(a, b);
      return (t.kind == KIND_MIXED) ? t : truth(1'b0);
   endfunction

   function automatic ival_type times(ival_type a, ival_type b);
      ival_type t;
      if (a.kind == KIND_NUMBER && b.kind == KIND_NUMBER)
         return make(KIND_NUMBER, q_mul(a.lo, b.lo), q_mul(a.lo, b.lo));
      if (is_real_kind(a) && is_real_kind(b))
         return span4(q_mul(a.lo, b.lo), q_mul(a.lo, b.hi),
                      q_mul(a.hi, b.lo), q_mul(a.hi, b.hi));
      if (is_real_kind(a) && is_bool_kind(b)) begin
         t = a;
         a = b;
         b = t;
      end
      if (is_bool_kind(a) && is_real_kind(b)) begin
         if (a.kind == KIND_TRUE) return b;
         if (a.kind == KIND_FALSE) return make(KIND_NUMBER, 0, 0);
         return make(KIND_INTERVAL, (b.lo < 0) ? b.lo : 0, (b.hi > 0) ? b.hi : 0);
      end
      return logic_and(a, b);
   endfunction

   function automatic ival_type divide(ival_type a, ival_type b);
      ival_type whole;
      longint p, q;
      whole = make(KIND_INTERVAL, VAL_MIN, VAL_MAX);
      if (!is_real_kind(a) || !is_real_kind(b)) return make(KIND_UNKNOWN, 0, 0);
      if (b.kind == KIND_NUMBER) begin
         if (b.lo == 0) return whole;
         p = q_div(a.lo, b.lo);
         if (a.kind == KIND_NUMBER) return make(KIND_NUMBER, p, p);
         q = q_div(a.hi, b.lo);
         return (p <= q) ? make(KIND_INTERVAL, p, q) : make(KIND_INTERVAL, q, p);
      end
      if ((b.lo > 0 || b.hi < 0) && b.lo != 0 && b.hi != 0)
         return span4(q_div(a.lo, b.lo), q_div(a.lo, b.hi),
                      q_div(a.hi, b.lo), q_div(a.hi, b.hi));
      return whole;
   endfunction

   function automatic ival_type operand(logic [2:0] k, logic [WIDTH-1:0] lo,
                                        logic [WIDTH-1:0] hi);
      ival_type v;
      v = make(KIND_UNKNOWN, 0, 0);
      if (k == KIND_INTERVAL) v = make(KIND_INTERVAL, sext(lo), sext(hi));
      else if (k == KIND_NUMBER) v = make(KIND_NUMBER, sext(lo), sext(lo));
      else if (k <= KIND_MIXED) v.kind = kind_type'(k);
      return v;
   endfunction

   function automatic rsp_item_type evaluate(req_item_type it);
      ival_type a, b, r;
      rsp_item_type o;
      a = operand(it.a_kind, it.a_lower, it.a_upper);
      b = operand(it.b_kind, it.b_lower, it.b_upper);
      r = make(KIND_UNKNOWN, 0, 0);
      case (it.command)
         CMD_ADD: begin
            if (a.kind == KIND_NUMBER && b.kind == KIND_NUMBER)
               r = make(KIND_NUMBER, clip(a.lo + b.lo), clip(a.lo + b.lo));
            else if (is_real_kind(a) && is_real_kind(b))
               r = make(KIND_INTERVAL, clip(a.lo + b.lo), clip(a.hi + b.hi));
         end
         CMD_SUB: begin
            if (a.kind == KIND_NUMBER && b.kind == KIND_NUMBER)
               r = make(KIND_NUMBER, clip(a.lo - b.lo), clip(a.lo - b.lo));
            else if (is_real_kind(a) && is_real_kind(b))
               r = make(KIND_INTERVAL, clip(a.lo - b.hi), clip(a.hi - b.lo));
         end
         CMD_MUL: r = times(a, b);
         CMD_DIV: r = divide(a, b);
         CMD_LT:  r = is_below(a, b);
         CMD_GT:  r = is_below(b, a);
         CMD_LE:  r = logic_or(is_below(a, b), equal_to(a, b));
         CMD_GE:  r = logic_or(is_below(b, a), equal_to(a, b));
         CMD_EQ:  r = equal_to(a, b);
         CMD_NOT: begin
            if (a.kind == KIND_TRUE) r = truth(1'b0);
            else if (a.kind == KIND_FALSE) r = truth(1'b1);
            else if (a.kind == KIND_MIXED) r = make(KIND_MIXED, 0, 0);
         end
         CMD_OR:  r = logic_or(a, b);
         CMD_AND: r = logic_and(a, b);
         CMD_NEG: begin
            if (a.kind == KIND_NUMBER) r = make(KIND_NUMBER, clip(-a.lo), clip(-a.lo));
            else if (a.kind == KIND_INTERVAL)
               r = make(KIND_INTERVAL, clip(-a.hi), clip(-a.lo));
         end
         default: ;
      endcase
      o.kind  = r.kind;
      o.lower = r.lo[WIDTH-1:0];
      o.upper = r.hi[WIDTH-1:0];
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [WIDTH-1:0] fx(int whole);
      return WIDTH'(whole) << FRAC;
   endfunction

   function automatic logic [WIDTH-1:0] rand_value();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: begin
            case ($urandom_range(0, 4))
               0: return {1'b1, {(WIDTH-1){1'b0}}};
               1: return {1'b0, {(WIDTH-1){1'b1}}};
               2: return '0;
               3: return '1;
               default: return fx(1);
            endcase
         end
         1, 2: return $urandom();
         default: return fx($urandom_range(0, 16) - 8) + WIDTH'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic push(logic [3:0] c, logic [2:0] ak, logic [WIDTH-1:0] al,
                       logic [WIDTH-1:0] au, logic [2:0] bk,
                       logic [WIDTH-1:0] bl, logic [WIDTH-1:0] bu);
      req_item_type it;
      it.command = c;
      it.a_kind  = ak;
      it.a_lower = al;
      it.a_upper = au;
      it.b_kind  = bk;
      it.b_lower = bl;
      it.b_upper = bu;
      pending_items.push_back(it);
   endtask

   // mostly real operands with ordered bounds; logic commands favor booleans
   task automatic rand_operand(logic [3:0] c, output logic [2:0] k,
                               output logic [WIDTH-1:0] lo, output logic [WIDTH-1:0] hi);
      logic [WIDTH-1:0] t;
      if (c >= CMD_NOT && c <= CMD_AND)
         k = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 3)) : 3'($urandom_range(0, 5));
      else
         k = ($urandom_range(0, 9) < 2) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 5));
      lo = rand_value();
      hi = rand_value();
      if ($urandom_range(0, 7) != 0 && $signed(lo) > $signed(hi)) begin
         t  = lo;
         lo = hi;
         hi = t;
      end
   endtask

   task automatic push_random(int count);
      req_item_type it;
      repeat (count) begin
         it.command = 4'($urandom_range(0, 12));
         rand_operand(it.command, it.a_kind, it.a_lower, it.a_upper);
         rand_operand(it.command, it.b_kind, it.b_lower, it.b_upper);
         pending_items.push_back(it);
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: new item on the falling edge once the previous one was taken
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      req_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            it = pending_items.pop_front();
            req_command <= it.command;
            req_a_kind  <= it.a_kind;
            req_a_lower <= it.a_lower;
            req_a_upper <= it.a_upper;
            req_b_kind  <= it.b_kind;
            req_b_lower <= it.b_lower;
            req_b_upper <= it.b_upper;
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here so the sender keeps offering items
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_requests > hold_served) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && hold_left == 0 && $urandom_range(0, 99) >= recv_idle_pct;
   end

   // ------------------------------------------------------------------
   // Monitor: predict on accept, compare each result with the oldest one
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      req_item_type it;
      rsp_item_type want;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         it.command = req_command;
         it.a_kind  = req_a_kind;
         it.a_lower = req_a_lower;
         it.a_upper = req_a_upper;
         it.b_kind  = req_b_kind;
         it.b_lower = req_b_lower;
         it.b_upper = req_b_upper;
         expected_results.push_back(evaluate(it));
         items_sent++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result kind %0d [%h, %h]", $realtime,
                        rsp_result_kind, rsp_result_lower, rsp_result_upper);
         end else begin
            want = expected_results.pop_front();
            if (want.kind !== rsp_result_kind || want.lower !== rsp_result_lower ||
                want.upper !== rsp_result_upper) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result %0d expected kind %0d [%h, %h], got kind %0d [%h, %h]",
                           $realtime, results_seen, want.kind, want.lower, want.upper,
                           rsp_result_kind, rsp_result_lower, rsp_result_upper);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      logic [WIDTH-1:0] vmax, vmin, one, neg_one;
      vmax    = {1'b0, {(WIDTH-1){1'b1}}};
      vmin    = {1'b1, {(WIDTH-1){1'b0}}};
      one     = fx(1);
      neg_one = fx(-1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: saturation at the extremes
      push(CMD_ADD, KIND_NUMBER, vmax, 0, KIND_NUMBER, vmax, 0);
      push(CMD_SUB, KIND_NUMBER, vmin, 0, KIND_NUMBER, vmax, 0);
      push(CMD_ADD, KIND_INTERVAL, vmin, vmax, KIND_NUMBER, neg_one, 0);
      push(CMD_SUB, KIND_INTERVAL, vmin, vmax, KIND_INTERVAL, vmin, vmax);
      push(CMD_MUL, KIND_NUMBER, vmax, 0, KIND_NUMBER, vmax, 0);
      push(CMD_MUL, KIND_NUMBER, vmin, 0, KIND_NUMBER, vmin, 0);
      push(CMD_MUL, KIND_INTERVAL, vmin, vmax, KIND_INTERVAL, neg_one, fx(3));
      // boolean times real, boolean times boolean
      push(CMD_MUL, KIND_FALSE, 0, 0, KIND_INTERVAL, neg_one, fx(2));
      push(CMD_MUL, KIND_NUMBER, fx(5), 0, KIND_TRUE, 0, 0);
      push(CMD_MUL, KIND_MIXED, 0, 0, KIND_INTERVAL, fx(2), fx(4));
      push(CMD_MUL, KIND_MIXED, 0, 0, KIND_TRUE, 0, 0);
      // division by zero and rounding
      push(CMD_DIV, KIND_NUMBER, one, 0, KIND_NUMBER, 0, 0);
      push(CMD_DIV, KIND_INTERVAL, one, fx(2), KIND_INTERVAL, neg_one, one);
      push(CMD_DIV, KIND_INTERVAL, one, fx(2), KIND_INTERVAL, 0, fx(3));
      push(CMD_DIV, KIND_NUMBER, vmin, 0, KIND_NUMBER, neg_one, 0);
      push(CMD_DIV, KIND_INTERVAL, neg_one, fx(7), KIND_INTERVAL, fx(3), fx(5));
      push(CMD_DIV, KIND_NUMBER, one, 0, KIND_NUMBER, fx(3), 0);
      // comparisons
      push(CMD_LT, KIND_NUMBER, one, 0, KIND_NUMBER, fx(2), 0);
      push(CMD_GT, KIND_INTERVAL, 0, fx(3), KIND_INTERVAL, fx(2), fx(5));
      push(CMD_LE, KIND_NUMBER, one, 0, KIND_NUMBER, one, 0);
      push(CMD_GE, KIND_INTERVAL, fx(4), fx(5), KIND_NUMBER, one, 0);
      push(CMD_EQ, KIND_INTERVAL, fx(4), one, KIND_NUMBER, fx(2), 0);   // unordered bounds
      // logic, negate, unhandled kinds
      push(CMD_NOT, KIND_MIXED, 0, 0, KIND_NUMBER, one, 0);
      push(CMD_OR, KIND_MIXED, 0, 0, KIND_FALSE, 0, 0);
      push(CMD_AND, KIND_TRUE, 0, 0, KIND_NUMBER, one, 0);
      push(CMD_NEG, KIND_NUMBER, vmin, 0, KIND_UNKNOWN, 0, 0);
      push(CMD_NEG, KIND_INTERVAL, vmin, one, KIND_UNKNOWN, 0, 0);
      wait_drained();

      send_idle_pct = 31;
      recv_idle_pct = 55;
      push_random(530);
      wait_drained();   // sender pauses until every result is back

      send_idle_pct = 55;
      recv_idle_pct = 31;
      push_random(530);
      wait_drained();

      // back-to-back with one long receiver hold so the pipeline backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      push_random(540);
      repeat (20) @(posedge clock);
      hold_requests = 1;
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items (directed corner cases plus random operands and commands)",
               items_sent);
      $display("Checked %0d results across idle, stall and back-pressure phases", results_seen);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding", expected_results.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
